// ----- hw/rtl/lzwc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_pkg: shared types and constants of the LZW byte compressor
// Item layouts, hash slot layout and the controller/datapath command and
// status groups.
// ---------------------------------------------------------------------------
package lzwc_pkg;

	localparam int unsigned CODE_BITS       = 16;
	localparam int unsigned FIRST_FREE_CODE = 256;
	localparam logic [7:0]  BYTE_FLIP       = 8'h80;
	localparam int unsigned EPOCH_W         = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 last_code;
	} out_item_t;

	// one hash slot: stream tag, key (prefix, byte) and the code it maps to
	typedef struct packed {
		logic [EPOCH_W-1:0]   tag;
		logic [CODE_BITS-1:0] prefix;
		logic [7:0]           data_byte;
		logic [CODE_BITS-1:0] code;
	} slot_t;

	typedef struct packed {
		logic accept;      // item taken this cycle
		logic probe_next;  // step to the next slot
		logic take_hit;    // prefix <= matched code
		logic miss;        // emit prefix, learn pair, restart from own code
		logic push_last;   // emit final code of stream
		logic end_stream;  // forget learned entries
		logic clear_step;  // clear one slot
	} cmd_t;

	typedef struct packed {
		logic prefix_valid;
		logic in_eos;
		logic eos_q;
		logic slot_hit;
		logic slot_empty;
		logic clear_last;
		logic epoch_wrap;
	} status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lzwc_stream_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_stream_if: valid/ready channel
// Carries one item per handshake; payload type set per instance.
// ---------------------------------------------------------------------------
interface lzwc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lzw_byte_compressor_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_byte_compressor_top: LZW compressor, bytes in, 16-bit codes out
// Controller FSM, hashed dictionary datapath and a two-entry result queue.
// ---------------------------------------------------------------------------
//  channel       dir  item fields                       handshake
//  byte_stream   in   data_byte[7:0], end_of_stream     valid/ready
//  code_stream   out  code[15:0], last_code             valid/ready
//
//  Steps: IDLE takes an item, WAIT reads its slot, CMP decides on a hit
//    or empty slot; further probe steps on the table's single read port
//    repeat WAIT and CMP; a stream's first byte only seeds the prefix.
//  Reset: the tags of all 2**(clog2(DICT_ENTRIES)+1) slots are cleared
//    after reset and again after every 255th stream; no item is taken then.
//  Stalls: up to two codes wait in the result queue; the block stalls only
//    when a code must be emitted and the queue is full.
// ---------------------------------------------------------------------------
module lzw_byte_compressor_top #(
	parameter int unsigned DICT_ENTRIES = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lzwc_stream_if.sink   byte_stream,
	lzwc_stream_if.source code_stream
);
	import lzwc_pkg::*;

	cmd_t      cmd;
	status_t   status;
	logic      q_full;
	logic      push;
	out_item_t push_item;
	in_item_t  in_item;
	out_item_t out_item;

	// input payload as a typed item
	assign in_item.data_byte     = byte_stream.payload.data_byte;
	assign in_item.end_of_stream = byte_stream.payload.end_of_stream;

	// sequencing: accept, probe loop, emit, flush, tag clearing
	lzwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_stream.valid),
		.in_ready (byte_stream.ready),
		.q_full   (q_full),
		.status   (status),
		.cmd      (cmd)
	);

	// prefix, code counter and the epoch-tagged hash table
	lzwc_datapath #(
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.status    (status),
		.push      (push),
		.push_item (push_item)
	);

	// result queue parts the core from the downstream ready
	lzwc_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.valid     (code_stream.valid),
		.ready     (code_stream.ready),
		.payload   (out_item)
	);

	assign code_stream.payload.code      = out_item.code;
	assign code_stream.payload.last_code = out_item.last_code;

endmodule
`default_nettype wire

// ----- hw/rtl/lzwc_out_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_out_queue: two-entry result queue
// Decouples code emission from the downstream ready.
// ---------------------------------------------------------------------------
module lzwc_out_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lzwc_pkg::out_item_t push_item,
	output logic                     full,
	output logic                     valid,
	input  wire logic                ready,
	output lzwc_pkg::out_item_t      payload
);
	import lzwc_pkg::*;

	out_item_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign payload = ent_q[rd_ptr_q];
	assign pop     = valid & ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2) || pop)
		else $error("push into full result queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_ptr_q != $past(rd_ptr_q))
		else $error("read pointer did not advance on pop");

endmodule
`default_nettype wire

// ----- hw/rtl/lzwc_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_datapath: prefix, code counter and hashed dictionary
// Linear-probe hash table tagged with a stream epoch; registered read.
// ---------------------------------------------------------------------------
module lzwc_datapath #(
	parameter int unsigned DICT_ENTRIES = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lzwc_pkg::cmd_t      cmd,
	input  wire lzwc_pkg::in_item_t  in_item,
	output lzwc_pkg::status_t        status,
	output logic                     push,
	output lzwc_pkg::out_item_t      push_item
);
	import lzwc_pkg::*;

	localparam int unsigned SLOT_W = $clog2(DICT_ENTRIES) + 1;
	localparam int unsigned SLOTS  = 2 ** SLOT_W;
	localparam int unsigned CODE_W = $clog2(DICT_ENTRIES + 1);
	localparam int unsigned MIX_W  = CODE_BITS + 8;

	slot_t                slot_mem [SLOTS];
	slot_t                rd_q;
	logic [SLOT_W-1:0]    probe_idx_q;
	logic [SLOT_W-1:0]    clear_idx_q;
	logic [7:0]           byte_q;
	logic                 eos_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 prefix_valid_q;
	logic [CODE_W-1:0]    next_free_q;
	logic [EPOCH_W-1:0]   epoch_q;

	logic                 dict_full;
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	slot_t                mem_wdata;
	logic [MIX_W-1:0]     mix;
	logic [SLOT_W-1:0]    home_idx;
	logic [CODE_BITS-1:0] own_code;
	logic [CODE_BITS-1:0] own_code_q;

	// home slot of (prefix, incoming byte)
	always_comb begin
		mix = MIX_W'(prefix_q)
			^ (MIX_W'(in_item.data_byte) << (SLOT_W - 8))
			^ MIX_W'(in_item.data_byte);
		home_idx = mix[SLOT_W-1:0];
	end

	assign own_code   = CODE_BITS'(in_item.data_byte ^ BYTE_FLIP);
	assign own_code_q = CODE_BITS'(byte_q ^ BYTE_FLIP);
	assign dict_full  = (next_free_q >= CODE_W'(DICT_ENTRIES));

	always_comb begin
		mem_we    = cmd.clear_step | (cmd.miss & ~dict_full);
		mem_waddr = cmd.clear_step ? clear_idx_q : probe_idx_q;
		mem_wdata = '0;
		if (!cmd.clear_step) begin
			mem_wdata.tag       = epoch_q;
			mem_wdata.prefix    = prefix_q;
			mem_wdata.data_byte = byte_q;
			mem_wdata.code      = CODE_BITS'(next_free_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= slot_mem[probe_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eos_q          <= 1'b0;
			probe_idx_q    <= '0;
			clear_idx_q    <= '0;
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			next_free_q    <= CODE_W'(FIRST_FREE_CODE);
			epoch_q        <= EPOCH_FIRST;
		end else begin
			if (cmd.accept) begin
				eos_q       <= in_item.end_of_stream;
				probe_idx_q <= home_idx;
				if (!prefix_valid_q) begin
					prefix_q       <= own_code;
					prefix_valid_q <= 1'b1;
				end
			end
			if (cmd.probe_next) begin
				probe_idx_q <= probe_idx_q + SLOT_W'(1);
			end
			if (cmd.take_hit) begin
				prefix_q <= rd_q.code;
			end
			if (cmd.miss) begin
				prefix_q <= own_code_q;
				if (!dict_full) begin
					next_free_q <= next_free_q + CODE_W'(1);
				end
			end
			if (cmd.end_stream) begin
				prefix_q       <= '0;
				prefix_valid_q <= 1'b0;
				next_free_q    <= CODE_W'(FIRST_FREE_CODE);
				epoch_q        <= (epoch_q == '1) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end
			if (cmd.clear_step) begin
				clear_idx_q <= clear_idx_q + SLOT_W'(1);
			end
		end
	end

	always_comb begin
		status.prefix_valid = prefix_valid_q;
		status.in_eos       = in_item.end_of_stream;
		status.eos_q        = eos_q;
		status.slot_empty   = (rd_q.tag != epoch_q);
		status.slot_hit     = (rd_q.tag == epoch_q) && (rd_q.prefix == prefix_q)
			&& (rd_q.data_byte == byte_q);
		status.clear_last   = (clear_idx_q == '1);
		status.epoch_wrap   = (epoch_q == '1);
	end

	assign push                = cmd.miss | cmd.push_last;
	assign push_item.code      = prefix_q;
	assign push_item.last_code = cmd.push_last;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= CODE_W'(DICT_ENTRIES))
		else $error("next free code beyond dictionary");
	a_prefix_known: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_valid_q |-> ((CODE_BITS + 1)'(prefix_q) < (CODE_BITS + 1)'(next_free_q)))
		else $error("prefix refers to an unassigned code");
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != EPOCH_CLEAR)
		else $error("live epoch equals cleared tag");
	a_miss_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.miss |-> status.slot_empty && !status.slot_hit)
		else $error("miss taken on an occupied slot");

endmodule
`default_nettype wire

// ----- hw/rtl/lzwc_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lzwc_ctrl: sequencing of accept, probe, emit, flush and clear
// ---------------------------------------------------------------------------
module lzwc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              q_full,
	input  wire lzwc_pkg::status_t status,
	output lzwc_pkg::cmd_t         cmd
);
	import lzwc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WAIT,
		ST_CMP,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid & ready_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_CMP: begin
				if (status.slot_hit) begin
					cmd.take_hit = 1'b1;
				end else if (status.slot_empty) begin
					cmd.miss = ~q_full;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			ST_FLUSH: begin
				cmd.push_last  = ~q_full;
				cmd.end_stream = ~q_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						if (!status.prefix_valid) begin
							state_q <= status.in_eos ? ST_FLUSH : ST_IDLE;
							ready_q <= ~status.in_eos;
						end else begin
							state_q <= ST_WAIT;
							ready_q <= 1'b0;
						end
					end
				end
				ST_WAIT: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmd.take_hit || cmd.miss) begin
						state_q <= status.eos_q ? ST_FLUSH : ST_IDLE;
						ready_q <= ~status.eos_q;
					end else if (cmd.probe_next) begin
						state_q <= ST_WAIT;
					end
				end
				ST_FLUSH: begin
					if (cmd.end_stream) begin
						state_q <= status.epoch_wrap ? ST_CLEAR : ST_IDLE;
						ready_q <= ~status.epoch_wrap;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_cmp_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> $past(state_q) == ST_WAIT || $past(state_q) == ST_CMP)
		else $error("compare without registered read");
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_hit, cmd.miss, cmd.probe_next, cmd.push_last, cmd.clear_step}))
		else $error("conflicting datapath actions");

endmodule
`default_nettype wire

// ----- dv/lzw_byte_compressor_top_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzw_byte_compressor_top_test: self-checking bench for the LZW compressor
// Drives byte items, predicts the emitted codes with a behavioral LZW
// dictionary, and checks every code item in order. Covers single-byte and
// long streams, a full dictionary, the tag clearing pass and output stalls.
// ---------------------------------------------------------------------------
module lzw_byte_compressor_top_test;
	import lzwc_pkg::*;

	localparam int unsigned DICT_SIZE      = 512;
	localparam int unsigned LONG_STREAM    = 320;   // enough misses to fill the dictionary
	localparam int unsigned PHASE_BYTES    = 78;
	localparam int unsigned SINGLE_STREAMS = 190;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned DRAIN_CYCLES   = 64;
	localparam int unsigned WATCHDOG_LIMIT = 30000; // covers the tag clearing pass

	// traffic shaping applied while a given item is in flight
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct {
		in_item_t item;
		pace_t    pace;
		bit       hold;   // receiver backs off for a long stretch when this item goes out
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lzwc_stream_if #(.payload_t(in_item_t))  byte_if ();
	lzwc_stream_if #(.payload_t(out_item_t)) code_if ();

	lzw_byte_compressor_top #(
		.DICT_ENTRIES(DICT_SIZE)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_if),
		.code_stream(code_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expectation stores
	byte_req_t   bytes_pending[$];
	out_item_t   codes_due[$];

	// predictor state: current prefix code and the learned (prefix, byte) pairs
	logic [15:0] cur_prefix;
	bit          have_prefix;
	int unsigned free_code;
	logic [15:0] learned[logic [23:0]];

	// generator state
	pace_t       gen_pace;
	bit          gen_hold;

	// handshake bookkeeping
	bit          in_fire;
	pace_t       drive_pace;
	int unsigned hold_token;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	// run statistics
	int unsigned errors;
	int unsigned n_bytes;
	int unsigned n_codes;
	int unsigned n_streams;
	int unsigned n_hits;
	bit          dict_full_seen;

	// -----------------------------------------------------------------------
	// Predictor: one accepted byte in, zero to two codes queued as due.
	// A miss emits the prefix and learns (prefix, byte) while room is left;
	// once the dictionary is full the pair is simply not learned.
	// -----------------------------------------------------------------------
	task automatic compress_byte(input in_item_t it);
		logic [15:0] own;
		logic [23:0] key;
		out_item_t   r;
		own = {8'h00, it.data_byte ^ BYTE_FLIP};
		key = {cur_prefix, it.data_byte};
		if (!have_prefix) begin
			// stream start: the byte only seeds the prefix
			cur_prefix  = own;
			have_prefix = 1'b1;
		end else if (learned.exists(key)) begin
			cur_prefix = learned[key];
			n_hits++;
		end else begin
			r.code      = cur_prefix;
			r.last_code = 1'b0;
			codes_due   = {codes_due, r};
			if (free_code < DICT_SIZE) begin
				learned[key] = free_code[15:0];
				free_code++;
			end else begin
				dict_full_seen = 1'b1;
			end
			cur_prefix = own;
		end
		if (it.end_of_stream) begin
			// flush, then forget everything learned in this stream
			r.code      = cur_prefix;
			r.last_code = 1'b1;
			codes_due   = {codes_due, r};
			cur_prefix  = '0;
			have_prefix = 1'b0;
			free_code   = FIRST_FREE_CODE;
			learned.delete();
			n_streams++;
		end
	endtask

	task automatic check_code(input out_item_t got);
		out_item_t want;
		n_codes++;
		if (codes_due.size() == 0) begin
			$display("%0t: code %h last %b arrived with none due",
				$time, got.code, got.last_code);
			errors++;
		end else begin
			want = codes_due.pop_front();
			if (got.code !== want.code) begin
				$display("%0t: code mismatch, expected %h, actual %h",
					$time, want.code, got.code);
				errors++;
			end
			if (got.last_code !== want.last_code) begin
				$display("%0t: last_code mismatch, expected %b, actual %b",
					$time, want.last_code, got.last_code);
				errors++;
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Stimulus builders
	// -----------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b, input bit eos);
		byte_req_t s;
		s.item.data_byte     = b;
		s.item.end_of_stream = eos;
		s.pace               = gen_pace;
		s.hold               = gen_hold;
		gen_hold             = 1'b0;
		bytes_pending        = {bytes_pending, s};
	endtask

	// Mostly short streams so the stream count passes the tag clearing
	// point; streams drawn from a few symbols get deep dictionary hits.
	task automatic add_random_streams(input pace_t pace, input int unsigned n_req);
		int unsigned added;
		int unsigned len;
		int unsigned kind;
		int unsigned n_sym;
		logic [7:0]  sym[4];
		gen_pace = pace;
		added    = 0;
		while (added < n_req) begin
			kind = $urandom_range(99);
			if (kind < 40)
				len = 1;
			else if (kind < 65)
				len = $urandom_range(3, 2);
			else if ($urandom_range(7) == 0)
				len = $urandom_range(32, 20);
			else
				len = $urandom_range(10, 2);
			n_sym = (kind < 65) ? 4 : $urandom_range(4, 1);
			foreach (sym[i])
				sym[i] = 8'($urandom_range(255));
			for (int k = 0; k < len; k++)
				add_byte(sym[$urandom_range(n_sym - 1)], k == len - 1);
			added += len;
		end
	endtask

	// -----------------------------------------------------------------------
	// Driver: presents the next pending byte at the falling edge. A byte
	// stays on the bus until the rising edge where it is taken; idle gaps
	// are only inserted between items.
	// -----------------------------------------------------------------------
	initial begin
		byte_if.valid   = 1'b0;
		byte_if.payload = '0;
		code_if.ready   = 1'b0;
	end

	always @(negedge clk) begin
		byte_req_t   s;
		bit          idle;
		if (!arst_n) begin
			byte_if.valid   <= 1'b0;
			byte_if.payload <= '0;
		end else if (!byte_if.valid || in_fire) begin
			case (drive_pace)
				PACE_SRC_IDLE: idle = $urandom_range(99) < 82;
				PACE_BOTH:     idle = $urandom_range(99) < 13;
				default:       idle = 1'b0;
			endcase
			if (bytes_pending.size() == 0 || idle) begin
				byte_if.valid <= 1'b0;
			end else begin
				s = bytes_pending.pop_front();
				byte_if.valid   <= 1'b1;
				byte_if.payload <= s.item;
				drive_pace      <= s.pace;
				if (s.hold)
					hold_token <= hold_token + 1;
			end
		end
	end

	// Receiver: random stalls per pace, plus a long hold-off on request
	// while the driver keeps offering bytes, so the result queue fills and
	// the block has to back-pressure its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			code_if.ready <= 1'b0;
		end else if (hold_seen != hold_token) begin
			hold_seen     <= hold_token;
			hold_left     <= HOLD_CYCLES;
			code_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			code_if.ready <= 1'b0;
		end else begin
			case (drive_pace)
				PACE_SNK_STALL: code_if.ready <= $urandom_range(99) >= 82;
				PACE_BOTH:      code_if.ready <= $urandom_range(99) >= 13;
				default:        code_if.ready <= 1'b1;
			endcase
		end
	end

	// Monitor: both channels sampled at the rising edge. Codes are checked
	// before the byte of the same edge is predicted; a byte cannot yield a
	// code at the very edge it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire      <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_fire <= byte_if.valid && byte_if.ready;
			if (code_if.valid && code_if.ready)
				check_code(code_if.payload);
			if (byte_if.valid && byte_if.ready) begin
				n_bytes++;
				compress_byte(byte_if.payload);
			end
			if ((code_if.valid && code_if.ready) || (byte_if.valid && byte_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog: no traffic on either side for too long means a hang.
	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles, %0d codes still due",
			$time, WATCHDOG_LIMIT, codes_due.size());
		$display("TEST FAILED");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		cur_prefix     = '0;
		have_prefix    = 1'b0;
		free_code      = FIRST_FREE_CODE;
		errors         = 0;
		n_bytes        = 0;
		n_codes        = 0;
		n_streams      = 0;
		n_hits         = 0;
		dict_full_seen = 1'b0;
		drive_pace     = PACE_FULL;
		gen_hold       = 1'b0;
		gen_pace       = PACE_FULL;

		// directed: byte extremes as single-byte streams
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		// ABABAB: learns pairs, hits them, ends on a hit (one code)
		repeat (3) begin
			add_byte(8'h41, 1'b0);
			add_byte(8'h42, 1'b0);
		end
		bytes_pending[$].item.end_of_stream = 1'b1;
		// end byte that also misses: two codes from one item
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b1);
		// same ABABAB again: the dictionary must start empty
		repeat (3) begin
			add_byte(8'h41, 1'b0);
			add_byte(8'h42, 1'b0);
		end
		bytes_pending[$].item.end_of_stream = 1'b1;
		// run of one symbol: growing chain of self-extending entries
		repeat (4) add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b1);

		// random streams at full rate; the receiver backs off at the start
		gen_hold = 1'b1;
		add_random_streams(PACE_FULL, PHASE_BYTES);

		// one long random stream runs the dictionary full and past it
		gen_pace = PACE_BOTH;
		for (int k = 0; k < LONG_STREAM; k++) begin
			gen_hold = (k == LONG_STREAM / 2);
			add_byte(8'($urandom_range(255)), k == LONG_STREAM - 1);
		end

		add_random_streams(PACE_SRC_IDLE, PHASE_BYTES);
		add_random_streams(PACE_SNK_STALL, PHASE_BYTES);
		add_random_streams(PACE_BOTH, PHASE_BYTES);

		// burst of single-byte streams to push past the tag clearing point
		gen_pace = PACE_FULL;
		repeat (SINGLE_STREAMS) add_byte(8'($urandom_range(255)), 1'b1);

		// reset: held low, then released away from the sampling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bytes_pending.size() != 0 || byte_if.valid)
			@(posedge clk);
		while (codes_due.size() != 0)
			@(posedge clk);
		// anything arriving now is a spurious code
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d streams, %0d codes checked, %0d dictionary hits",
			n_bytes, n_streams, n_codes, n_hits);
		$display("Dictionary ran full: %s; long receiver hold-offs: %0d",
			dict_full_seen ? "yes" : "no", hold_token);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_stream_if.sv
hw/rtl/lzwc_out_queue.sv
hw/rtl/lzwc_datapath.sv
hw/rtl/lzwc_ctrl.sv
hw/rtl/lzw_byte_compressor_top.sv
dv/lzw_byte_compressor_top_test.sv
